>>> design/dhtd_pkg.sv
// Package with the shared types and constants of the edge time decoder.
`timescale 1ns / 1ps

package dhtd_pkg;

  localparam int unsigned FRAME_BITS_DEF = 40;
  localparam int unsigned TIME_W = 16;
  localparam int unsigned PERIOD_W = 17;

  localparam logic [15:0] THRESHOLD_RST = 16'h000A;
  localparam logic [16:0] PERIOD_RST = 17'd50000;
  localparam logic [16:0] PERIOD_FULL = 17'h10000;

  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  typedef enum logic [1:0] {
    OP_START,
    OP_EDGE,
    OP_REBASE
  } mod_op_e;

  typedef struct packed {
    logic        kind;
    logic [15:0] edge_time;
  } in_word_t;

  typedef struct packed {
    logic [15:0] humidity;
    logic [15:0] temperature;
    logic        checksum_ok;
  } out_word_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [16:0] period_eff;
  } cfg_t;

  typedef struct packed {
    mod_op_e     op;
    logic [15:0] raw;
    logic [15:0] red;
  } mod_item_t;

endpackage

>>> design/dhtd_cfg_regs.sv
// Register file behind the APB-style configuration port.
`timescale 1ns / 1ps

module dhtd_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output dhtd_pkg::cfg_t     cfg_o,
  output logic               period_wr_o
);

  logic [15:0] threshold_q;
  logic [16:0] period_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign period_wr_o = wr_en && (paddr[2] == dhtd_pkg::REG_PERIOD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= dhtd_pkg::THRESHOLD_RST;
      period_q    <= dhtd_pkg::PERIOD_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        dhtd_pkg::REG_THRESHOLD: threshold_q <= pwdata[15:0];
        dhtd_pkg::REG_PERIOD:    period_q    <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      dhtd_pkg::REG_THRESHOLD: prdata = {16'h0000, threshold_q};
      dhtd_pkg::REG_PERIOD:    prdata = {15'h0000, period_q};
      default:                 prdata = 32'h0000_0000;
    endcase
  end

  // A period of zero stands for the full 16-bit counter range.
  assign cfg_o.threshold  = threshold_q;
  assign cfg_o.period_eff = (period_q == '0) ? dhtd_pkg::PERIOD_FULL : period_q;

endmodule

>>> design/dhtd_mod_pipe.sv
// Pipelined restoring remainder unit that reduces timestamps modulo the period.
`timescale 1ns / 1ps

module dhtd_mod_pipe (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [16:0]           period_i,
  input  logic                  up_valid_i,
  input  dhtd_pkg::mod_item_t   up_item_i,
  output logic                  up_stall_o,
  output logic                  dn_valid_o,
  output dhtd_pkg::mod_item_t   dn_item_o,
  input  logic                  dn_stall_i
);

  localparam int unsigned TW = dhtd_pkg::TIME_W;
  localparam int unsigned STEPS = 4;
  localparam int unsigned NSTG = TW / STEPS;

  // Four trial subtractions of the shifted period, highest shift first.
  function automatic logic [15:0] reduce_steps(logic [15:0] r, logic [16:0] p,
                                               int unsigned top_k);
    logic [31:0] sh;
    logic [15:0] v;
    v = r;
    for (int unsigned j = 0; j < STEPS; j++) begin
      sh = {15'h0000, p} << (top_k - j);
      if ({16'h0000, v} >= sh) begin
        v = v - sh[15:0];
      end
    end
    return v;
  endfunction

  logic                v_q    [NSTG];
  dhtd_pkg::mod_item_t item_q [NSTG];
  logic                take   [NSTG];
  logic                src_v  [NSTG];
  dhtd_pkg::mod_item_t src    [NSTG];
  dhtd_pkg::mod_item_t nxt    [NSTG];

  always_comb begin
    take[NSTG-1] = !v_q[NSTG-1] || !dn_stall_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      take[s] = !v_q[s] || take[s+1];
    end
  end

  always_comb begin
    src_v[0] = up_valid_i;
    src[0]   = up_item_i;
    for (int unsigned s = 1; s < NSTG; s++) begin
      src_v[s] = v_q[s-1];
      src[s]   = item_q[s-1];
    end
    for (int unsigned s = 0; s < NSTG; s++) begin
      nxt[s].op  = src[s].op;
      nxt[s].raw = src[s].raw;
      nxt[s].red = reduce_steps(src[s].red, period_i, TW - 1 - STEPS * s);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned s = 0; s < NSTG; s++) begin
        v_q[s] <= 1'b0;
      end
    end else begin
      for (int unsigned s = 0; s < NSTG; s++) begin
        if (take[s]) begin
          v_q[s] <= src_v[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned s = 0; s < NSTG; s++) begin
      if (take[s]) begin
        item_q[s] <= nxt[s];
      end
    end
  end

  assign up_stall_o = !take[0];
  assign dn_valid_o = v_q[NSTG-1];
  assign dn_item_o  = item_q[NSTG-1];

endmodule

>>> design/dhtd_frame.sv
// Frame state: bit slicing, checksum test, held words and the result register.
`timescale 1ns / 1ps

module dhtd_frame #(
  parameter int unsigned FRAME_BITS = dhtd_pkg::FRAME_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dhtd_pkg::cfg_t        cfg_i,
  input  logic                  item_valid_i,
  input  dhtd_pkg::mod_item_t   item_i,
  output logic                  item_stall_o,
  output logic [15:0]           last_raw_o,
  output logic                  out_valid_o,
  output dhtd_pkg::out_word_t   out_word_o,
  input  logic                  out_stall_i
);

  localparam int unsigned CW = $clog2(FRAME_BITS + 2);
  localparam logic [CW-1:0] LAST_CNT = CW'(FRAME_BITS + 1);

  logic                  idle_q;
  logic [CW-1:0]         cnt_q;
  logic [15:0]           last_raw_q;
  logic [15:0]           last_red_q;
  logic [FRAME_BITS-1:0] frame_q;
  logic [15:0]           held_hum_q;
  logic [15:0]           held_temp_q;
  logic                  out_v_q;
  dhtd_pkg::out_word_t   out_q;

  logic                  is_edge;
  logic                  will_result;
  logic                  out_ready;
  logic                  fire;
  logic [16:0]           interval;
  logic                  new_bit;
  logic [FRAME_BITS-1:0] frame_nx;
  logic [63:0]           word;
  logic [9:0]            sum;
  logic                  ok;

  assign is_edge     = (item_i.op == dhtd_pkg::OP_EDGE);
  assign will_result = is_edge && !idle_q && (cnt_q == LAST_CNT);
  assign out_ready   = !out_v_q || !out_stall_i;
  assign fire        = item_valid_i && (!will_result || out_ready);
  assign item_stall_o = will_result && !out_ready;

  // Both times are already reduced below the period, so one wrap suffices.
  always_comb begin
    if (item_i.red >= last_red_q) begin
      interval = {1'b0, item_i.red} - {1'b0, last_red_q};
    end else begin
      interval = {1'b0, item_i.red} + cfg_i.period_eff - {1'b0, last_red_q};
    end
  end

  assign new_bit  = interval > {1'b0, cfg_i.threshold};
  assign frame_nx = {frame_q[FRAME_BITS-2:0], new_bit};
  assign word     = 64'(frame_nx);
  assign sum      = 10'(word[15:8]) + 10'(word[23:16]) + 10'(word[31:24])
                  + 10'(word[39:32]);
  assign ok       = (sum[7:0] == word[7:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q      <= 1'b1;
      cnt_q       <= '0;
      last_raw_q  <= '0;
      last_red_q  <= '0;
      frame_q     <= '0;
      held_hum_q  <= '0;
      held_temp_q <= '0;
      out_v_q     <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i && !(fire && will_result)) begin
        out_v_q <= 1'b0;
      end
      if (fire) begin
        unique case (item_i.op)
          dhtd_pkg::OP_START: begin
            idle_q  <= 1'b0;
            cnt_q   <= '0;
            frame_q <= '0;
          end
          dhtd_pkg::OP_EDGE: begin
            if (!idle_q) begin
              priority if (cnt_q == '0) begin
                cnt_q <= CW'(1);
              end else if (cnt_q == CW'(1)) begin
                last_raw_q <= item_i.raw;
                last_red_q <= item_i.red;
                cnt_q      <= CW'(2);
              end else begin
                frame_q    <= frame_nx;
                last_raw_q <= item_i.raw;
                last_red_q <= item_i.red;
                if (cnt_q == LAST_CNT) begin
                  idle_q  <= 1'b1;
                  cnt_q   <= '0;
                  out_v_q <= 1'b1;
                  if (ok) begin
                    held_hum_q  <= word[39:24];
                    held_temp_q <= word[23:8];
                  end
                end else begin
                  cnt_q <= cnt_q + CW'(1);
                end
              end
            end
          end
          dhtd_pkg::OP_REBASE: begin
            last_red_q <= item_i.red;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && will_result) begin
      out_q.humidity    <= ok ? word[39:24] : held_hum_q;
      out_q.temperature <= ok ? word[23:8] : held_temp_q;
      out_q.checksum_ok <= ok;
    end
  end

  assign last_raw_o  = last_raw_q;
  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

`ifndef ASSERT_OFF
  a_result_closes_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && will_result) |=> (out_v_q && idle_q))
    else $error("frame end did not give a result and return to idle");

  a_idle_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> (cnt_q == '0))
    else $error("edge count not clear while idle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_CNT)
    else $error("edge count beyond frame length");

  a_held_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && will_result) |=> ($stable(held_hum_q) && $stable(held_temp_q)))
    else $error("held words changed outside a frame end");
`endif

endmodule

>>> design/dht22_edge_time_decoder.sv
// Top level of the DHT22 edge time decoder.
//
//   channel   direction  handshake               payload
//   in        input      in_valid_i / in_stall_o   in_word_i (kind, edge_time)
//   out       output     out_valid_o / out_stall_i out_word_o (humidity, temperature,
//                                                  checksum_ok)
//   config    input      psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// One word is accepted per cycle while in_stall_o is low; the result for the edge that ends
// the frame is registered through the four-stage remainder pipeline and the frame register.
// Reset clears the frame state, the held words and the registers to their defaults.
// A stalled result holds a frame-ending edge at the pipeline exit; three more words fit
// behind it before the input stalls.
// A period write queues one rebase word that holds off input until the pipeline takes it.
`timescale 1ns / 1ps

module dht22_edge_time_decoder #(
  parameter int unsigned FRAME_BITS = dhtd_pkg::FRAME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dhtd_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dhtd_pkg::out_word_t  out_word_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  dhtd_pkg::cfg_t      cfg;
  logic                period_wr;
  logic                rebase_pend_q;
  logic                pipe_up_stall;
  logic                entry_valid;
  dhtd_pkg::mod_item_t entry;
  logic                pipe_valid;
  dhtd_pkg::mod_item_t pipe_item;
  logic                pipe_stall;
  logic [15:0]         last_raw;

  dhtd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cfg_o       (cfg),
    .period_wr_o (period_wr)
  );

  // After a period change the stored reference time is reduced again.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rebase_pend_q <= 1'b0;
    end else if (period_wr) begin
      rebase_pend_q <= 1'b1;
    end else if (rebase_pend_q && !pipe_up_stall) begin
      rebase_pend_q <= 1'b0;
    end
  end

  always_comb begin
    if (rebase_pend_q) begin
      entry.op  = dhtd_pkg::OP_REBASE;
      entry.raw = last_raw;
      entry.red = last_raw;
    end else begin
      entry.op  = in_word_i.kind ? dhtd_pkg::OP_EDGE : dhtd_pkg::OP_START;
      entry.raw = in_word_i.edge_time;
      entry.red = in_word_i.edge_time;
    end
  end

  assign entry_valid = rebase_pend_q || in_valid_i;
  assign in_stall_o  = rebase_pend_q || pipe_up_stall;

  dhtd_mod_pipe u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .period_i   (cfg.period_eff),
    .up_valid_i (entry_valid),
    .up_item_i  (entry),
    .up_stall_o (pipe_up_stall),
    .dn_valid_o (pipe_valid),
    .dn_item_o  (pipe_item),
    .dn_stall_i (pipe_stall)
  );

  dhtd_frame #(
    .FRAME_BITS (FRAME_BITS)
  ) u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .item_valid_i (pipe_valid),
    .item_i       (pipe_item),
    .item_stall_o (pipe_stall),
    .last_raw_o   (last_raw),
    .out_valid_o  (out_valid_o),
    .out_word_o   (out_word_o),
    .out_stall_i  (out_stall_i)
  );

endmodule

>>> test/tb_dht22_edge_time_decoder.sv
// Testbench for the edge time decoder: directed table and random frames against a predictor.
`timescale 1ns / 1ps

module tb_dht22_edge_time_decoder;

  localparam int unsigned FRAME_LEN = dhtd_pkg::FRAME_BITS_DEF;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef enum logic [1:0] {
    ROW_START,
    ROW_RUN,
    ROW_FRAME,
    ROW_CFG
  } row_op_e;

  typedef struct packed {
    row_op_e             op;
    logic [15:0]         t0;
    logic [7:0]          reps;
    logic [15:0]         stepv;
    logic [39:0]         pat;
    logic                reg_sel;
    logic [31:0]         val;
    logic                typed;
    dhtd_pkg::out_word_t want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  dhtd_pkg::in_word_t  in_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  dhtd_pkg::out_word_t out_word_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  logic [15:0] cfg_thr;
  logic [16:0] cfg_period;
  bit          dec_idle;
  int unsigned dec_edges;
  logic [15:0] dec_last;
  logic [39:0] dec_frame;
  logic [15:0] dec_hum;
  logic [15:0] dec_temp;

  dhtd_pkg::out_word_t readings_q[$];
  int unsigned bad_count = 0;
  int unsigned readings_seen = 0;
  int unsigned words_fed = 0;
  int unsigned reg_writes = 0;
  bit          feed_gaps = 1'b1;
  bit          drain_gaps = 1'b1;
  bit          hold_req = 1'b0;

  dir_row_t    dir_tab[31];

  dht22_edge_time_decoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned tick_gap(logic [15:0] now, logic [15:0] prev);
    int unsigned p;
    int unsigned n;
    int unsigned b;
    p = (cfg_period == '0) ? 32'd65536 : 32'(cfg_period);
    n = 32'(now);
    b = 32'(prev);
    return (n + p - (b % p)) % p;
  endfunction

  // Advances the decoder state by one accepted word; returns 1 when a reading is due.
  function automatic bit decode_word(dhtd_pkg::in_word_t w,
                                     output dhtd_pkg::out_word_t res, output bit dropped);
    int unsigned gap;
    logic [7:0] sum;
    res = '0;
    dropped = 1'b0;
    if (w.kind == 1'b0) begin
      dec_idle = 1'b0;
      dec_edges = 0;
      dec_frame = '0;
      return 1'b0;
    end
    if (dec_idle) begin
      dropped = 1'b1;
      return 1'b0;
    end
    if (dec_edges == 0) begin
      dec_edges = 1;
      return 1'b0;
    end
    if (dec_edges == 1) begin
      dec_last = w.edge_time;
      dec_edges = 2;
      return 1'b0;
    end
    gap = tick_gap(w.edge_time, dec_last);
    dec_frame = {dec_frame[38:0], (gap > 32'(cfg_thr))};
    dec_last = w.edge_time;
    dec_edges++;
    if (dec_edges < FRAME_LEN + 2) return 1'b0;
    sum = dec_frame[39:32] + dec_frame[31:24] + dec_frame[23:16] + dec_frame[15:8];
    res.checksum_ok = (sum == dec_frame[7:0]);
    if (res.checksum_ok) begin
      dec_hum = dec_frame[39:24];
      dec_temp = dec_frame[23:8];
    end
    dec_idle = 1'b1;
    dec_edges = 0;
    res.humidity = dec_hum;
    res.temperature = dec_temp;
    return 1'b1;
  endfunction

  // Picks the next timestamp so that the interval encodes the wanted bit.
  function automatic logic [15:0] next_stamp(logic [15:0] prev, bit b);
    int unsigned p;
    int unsigned pm1;
    int unsigned lo;
    int unsigned hi;
    int unsigned d;
    int unsigned t;
    p = (cfg_period == '0) ? 32'd65536 : 32'(cfg_period);
    pm1 = p - 1;
    if (b) begin
      lo = (32'(cfg_thr) + 1 > pm1) ? pm1 : 32'(cfg_thr) + 1;
      hi = pm1;
    end else begin
      lo = 0;
      hi = (32'(cfg_thr) > pm1) ? pm1 : 32'(cfg_thr);
    end
    d = $urandom_range(hi, lo);
    t = (32'(prev) % p + d) % p;
    if (t + p <= 65535 && $urandom_range(0, 7) == 0) t = t + p;
    return t[15:0];
  endfunction

  task automatic feed_pause(int unsigned n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_word(logic kind, logic [15:0] stamp, bit typed,
                           dhtd_pkg::out_word_t want);
    dhtd_pkg::in_word_t  w;
    dhtd_pkg::out_word_t res;
    bit                  dropped;
    w.kind = kind;
    w.edge_time = stamp;
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_word(w, res, dropped)) readings_q.push_back(typed ? want : res);
    if (!dropped) words_fed++;
    if (feed_gaps && $urandom_range(0, 9) == 0) feed_pause($urandom_range(1, 15));
  endtask

  task automatic send_frame(logic [39:0] pat, bit typed, dhtd_pkg::out_word_t want);
    logic [15:0] prev;
    send_word(1'b0, 16'($urandom), 1'b0, '0);
    send_word(1'b1, 16'($urandom), 1'b0, '0);
    prev = 16'($urandom);
    send_word(1'b1, prev, 1'b0, '0);
    for (int i = 39; i >= 0; i--) begin
      prev = next_stamp(prev, pat[i]);
      send_word(1'b1, prev, typed && i == 0, want);
    end
  endtask

  task automatic reg_write(logic sel, logic [31:0] val);
    in_valid_i <= 1'b0;
    while (readings_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == dhtd_pkg::REG_THRESHOLD) cfg_thr = val[15:0];
    else cfg_period = val[16:0];
    reg_writes++;
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (drain_gaps && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : watch_readings
    dhtd_pkg::out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      readings_seen++;
      if (readings_q.size() == 0) begin
        bad_count++;
        if (bad_count <= 10) $display("Unexpected reading: %h", out_word_o);
      end else begin
        want = readings_q.pop_front();
        if (out_word_o.humidity !== want.humidity ||
            out_word_o.temperature !== want.temperature ||
            out_word_o.checksum_ok !== want.checksum_ok) begin
          bad_count++;
          if (bad_count <= 10)
            $display("Reading mismatch: expected hum %h temp %h ok %b, got hum %h temp %h ok %b",
                     want.humidity, want.temperature, want.checksum_ok,
                     out_word_o.humidity, out_word_o.temperature, out_word_o.checksum_ok);
        end
      end
    end
  end

  initial begin
    logic [15:0] stamp;
    logic [15:0] hum;
    logic [15:0] temp;
    logic [7:0]  sum;
    int unsigned phase;
    int unsigned pick;
    bit          late;

    cfg_thr = dhtd_pkg::THRESHOLD_RST;
    cfg_period = dhtd_pkg::PERIOD_RST;
    dec_idle = 1'b1;
    dec_edges = 0;
    dec_last = '0;
    dec_frame = '0;
    dec_hum = '0;
    dec_temp = '0;

    dir_tab[0]  = '{ROW_RUN, 16'd100, 8'd3, 16'd7, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[1]  = '{ROW_START, 16'hFFFF, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[2]  = '{ROW_RUN, 16'd0, 8'd42, 16'd5, 40'h0, 1'b0, 32'h0, 1'b1,
                    '{16'h0000, 16'h0000, 1'b1}};
    dir_tab[3]  = '{ROW_START, 16'h0000, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[4]  = '{ROW_RUN, 16'd0, 8'd42, 16'd11, 40'h0, 1'b0, 32'h0, 1'b1,
                    '{16'h0000, 16'h0000, 1'b0}};
    dir_tab[5]  = '{ROW_START, 16'hFFFF, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[6]  = '{ROW_RUN, 16'd0, 8'd42, 16'd10, 40'h0, 1'b0, 32'h0, 1'b1,
                    '{16'h0000, 16'h0000, 1'b1}};
    dir_tab[7]  = '{ROW_FRAME, 16'd0, 8'd0, 16'd0, 40'h01_2345_67D0, 1'b0, 32'h0, 1'b1,
                    '{16'h0123, 16'h4567, 1'b1}};
    dir_tab[8]  = '{ROW_FRAME, 16'd0, 8'd0, 16'd0, 40'hAA_AA55_5500, 1'b0, 32'h0, 1'b1,
                    '{16'h0123, 16'h4567, 1'b0}};
    dir_tab[9]  = '{ROW_START, 16'h0000, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[10] = '{ROW_RUN, 16'd300, 8'd20, 16'd11, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[11] = '{ROW_FRAME, 16'd0, 8'd0, 16'd0, 40'hFF_FFFF_FFFC, 1'b0, 32'h0, 1'b1,
                    '{16'hFFFF, 16'hFFFF, 1'b1}};
    dir_tab[12] = '{ROW_RUN, 16'd5, 8'd4, 16'd3, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[13] = '{ROW_START, 16'h0000, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[14] = '{ROW_RUN, 16'd49990, 8'd42, 16'd11, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[15] = '{ROW_START, 16'hFFFF, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[16] = '{ROW_RUN, 16'd65535, 8'd42, 16'd1, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[17] = '{ROW_CFG, 16'd0, 8'd0, 16'd0, 40'h0, dhtd_pkg::REG_THRESHOLD, 32'd0,
                    1'b0, '0};
    dir_tab[18] = '{ROW_START, 16'h0000, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[19] = '{ROW_RUN, 16'd7, 8'd42, 16'd0, 40'h0, 1'b0, 32'h0, 1'b1,
                    '{16'h0000, 16'h0000, 1'b1}};
    dir_tab[20] = '{ROW_START, 16'hFFFF, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[21] = '{ROW_RUN, 16'd0, 8'd42, 16'd1, 40'h0, 1'b0, 32'h0, 1'b1,
                    '{16'h0000, 16'h0000, 1'b0}};
    dir_tab[22] = '{ROW_CFG, 16'd0, 8'd0, 16'd0, 40'h0, dhtd_pkg::REG_PERIOD, 32'd1,
                    1'b0, '0};
    dir_tab[23] = '{ROW_START, 16'h0000, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[24] = '{ROW_RUN, 16'd12345, 8'd42, 16'd777, 40'h0, 1'b0, 32'h0, 1'b1,
                    '{16'h0000, 16'h0000, 1'b1}};
    dir_tab[25] = '{ROW_CFG, 16'd0, 8'd0, 16'd0, 40'h0, dhtd_pkg::REG_PERIOD, 32'd0,
                    1'b0, '0};
    dir_tab[26] = '{ROW_CFG, 16'd0, 8'd0, 16'd0, 40'h0, dhtd_pkg::REG_THRESHOLD, 32'd65535,
                    1'b0, '0};
    dir_tab[27] = '{ROW_START, 16'hFFFF, 8'd1, 16'd0, 40'h0, 1'b0, 32'h0, 1'b0, '0};
    dir_tab[28] = '{ROW_RUN, 16'd0, 8'd42, 16'd40000, 40'h0, 1'b0, 32'h0, 1'b1,
                    '{16'h0000, 16'h0000, 1'b1}};
    dir_tab[29] = '{ROW_CFG, 16'd0, 8'd0, 16'd0, 40'h0, dhtd_pkg::REG_THRESHOLD, 32'd300,
                    1'b0, '0};
    dir_tab[30] = '{ROW_FRAME, 16'd0, 8'd0, 16'd0, 40'h00_FF00_FFFE, 1'b0, 32'h0, 1'b1,
                    '{16'h00FF, 16'h00FF, 1'b1}};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].op)
        ROW_START: send_word(1'b0, dir_tab[i].t0, 1'b0, '0);
        ROW_RUN: begin
          for (int j = 0; j < dir_tab[i].reps; j++) begin
            stamp = 16'(dir_tab[i].t0 + j * dir_tab[i].stepv);
            send_word(1'b1, stamp, dir_tab[i].typed && j == dir_tab[i].reps - 1,
                      dir_tab[i].want);
          end
        end
        ROW_FRAME: send_frame(dir_tab[i].pat, dir_tab[i].typed, dir_tab[i].want);
        default: reg_write(dir_tab[i].reg_sel, dir_tab[i].val);
      endcase
    end

    phase = 0;
    while (words_fed < 1250) begin
      late = (words_fed >= 1080);
      if (!late) begin
        case (phase % 8)
          0: begin
            reg_write(dhtd_pkg::REG_THRESHOLD, 32'd10);
            reg_write(dhtd_pkg::REG_PERIOD, 32'd50000);
          end
          1: begin
            reg_write(dhtd_pkg::REG_THRESHOLD, 32'd0);
            reg_write(dhtd_pkg::REG_PERIOD, 32'd65536);
          end
          2: begin
            reg_write(dhtd_pkg::REG_THRESHOLD, 32'd65535);
            reg_write(dhtd_pkg::REG_PERIOD, 32'd50000);
          end
          3: begin
            reg_write(dhtd_pkg::REG_THRESHOLD, 32'd300);
            reg_write(dhtd_pkg::REG_PERIOD, 32'd0);
          end
          4: begin
            reg_write(dhtd_pkg::REG_THRESHOLD, 32'd1000);
            reg_write(dhtd_pkg::REG_PERIOD, 32'd131071);
          end
          5: begin
            reg_write(dhtd_pkg::REG_THRESHOLD, 32'd3);
            reg_write(dhtd_pkg::REG_PERIOD, 32'd1);
          end
          6: begin
            reg_write(dhtd_pkg::REG_THRESHOLD, $urandom_range(0, 65535));
            reg_write(dhtd_pkg::REG_PERIOD, $urandom_range(0, 131071));
          end
          default: begin
            reg_write(dhtd_pkg::REG_THRESHOLD, $urandom_range(0, 3000));
            reg_write(dhtd_pkg::REG_PERIOD, $urandom_range(3000, 65536));
          end
        endcase
      end
      feed_gaps = !late && $urandom_range(0, 3) != 0;
      drain_gaps = !late && $urandom_range(0, 3) != 0;

      if (phase == 0) begin
        // Back up the pipeline behind a long output stall.
        feed_gaps = 1'b0;
        hold_req = 1'b1;
        repeat (3) begin
          hum = 16'($urandom);
          temp = 16'($urandom);
          sum = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];
          send_frame({hum, temp, sum}, 1'b0, '0);
        end
        feed_gaps = !late && $urandom_range(0, 3) != 0;
      end

      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          hum = 16'($urandom);
          temp = 16'($urandom);
          sum = hum[15:8] + hum[7:0] + temp[15:8] + temp[7:0];
          send_frame({hum, temp, sum}, 1'b0, '0);
        end else if (pick < 75) begin
          send_frame({$urandom, 8'($urandom)}, 1'b0, '0);
        end else if (pick < 85) begin
          send_word(1'b0, 16'($urandom), 1'b0, '0);
          repeat ($urandom_range(0, 41)) send_word(1'b1, 16'($urandom), 1'b0, '0);
        end else if (pick < 93) begin
          repeat ($urandom_range(1, 5)) send_word(1'b1, 16'($urandom), 1'b0, '0);
        end else begin
          send_word(1'b0, 16'($urandom), 1'b0, '0);
          repeat (FRAME_LEN + 2) send_word(1'b1, 16'($urandom), 1'b0, '0);
        end
        if (!late && (phase == 3 || $urandom_range(0, 9) == 0)) begin
          in_valid_i <= 1'b0;
          while (readings_q.size() != 0) @(posedge clk_i);
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
      end
      phase++;
    end

    in_valid_i <= 1'b0;
    for (int i = 0; i < 20000 && readings_q.size() != 0; i++) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (readings_q.size() != 0) begin
      bad_count += readings_q.size();
      $display("%0d readings never arrived", readings_q.size());
    end

    $display("Fed %0d decoder words over %0d register writes and %0d random phases.",
             words_fed, reg_writes, phase);
    $display("Checked %0d readings, %0d mismatching.", readings_seen, bad_count);
    if (bad_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
